// ===== rtl/core/decint_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decint_pkg
// Types and constants shared by the decimal integer parser.
// ----------------------------------------------------------------------------
package decint_pkg;

  typedef enum logic [0:0] {
    PH_SKIP = 1'b0,
    PH_NUM  = 1'b1
  } phase_t;

  typedef enum logic [1:0] {
    WMODE_16 = 2'd0,
    WMODE_32 = 2'd1,
    WMODE_64 = 2'd2,
    WMODE_RSV = 2'd3
  } wmode_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] KEEP_16 = 5'd6;
  localparam logic [4:0] KEEP_32 = 5'd11;
  localparam logic [4:0] KEEP_64 = 5'd21;

  localparam logic [63:0] MAX_16 = 64'h0000_0000_0000_7FFF;
  localparam logic [63:0] MAX_32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MAX_64 = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [63:0] ACC_DIV10 = 64'd922337203685477580;
  localparam logic [63:0] MAG_TOP   = 64'h8000_0000_0000_0000;
  localparam logic [15:0] CNT_MAX   = 16'hFFFF;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_DATA_W  = 2;

endpackage : decint_pkg
`default_nettype wire

// ===== rtl/core/decimal_integer_parser.sv =====
// Result: the result word for a terminating character is registered as the character is
//   accepted and is visible on out_* in the next cycle.
// Throughput: one character per cycle; input stalls only while a result word waits.
// Reset (rst_n low, synchronous): width mode 32-bit, parser skipping spaces, output empty.
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_integer_parser
// Saturating ASCII decimal integer parser, one character per word.
// ----------------------------------------------------------------------------
module decimal_integer_parser (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [decint_pkg::CFG_DATA_W-1:0]  cfg_data,   // [1:0] width_mode
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [decint_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [decint_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [63:0] value, [79:64] consumed_count
  output logic [decint_pkg::OUT_TUSER_W-1:0]      out_tuser   // [0] overflow, [1] number_found,
                                                              // [2] sign_returned
);
  import decint_pkg::*;

  wmode_t      wmode_r;
  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic        sign_r, sign_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  kept_r, kept_nxt;
  logic [15:0] extra_r, extra_nxt;
  logic        aovf_r, aovf_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  logic        in_fire, is_digit, is_sign, is_space, term;
  logic [3:0]  dig;
  logic [4:0]  keep_lim;
  logic [63:0] acc_x10;
  logic [63:0] max_pos, lim, mag, val;
  logic        found, ovf, sret;
  logic [16:0] cnt_sum;
  logic [15:0] cnt;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign is_digit = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign is_sign  = (in_tdata == CH_MINUS) || (in_tdata == CH_PLUS);
  assign is_space = (in_tdata == CH_SPACE);
  assign dig      = 4'(in_tdata - CH_ZERO);
  assign term     = !is_digit && ((phase_r == PH_NUM) || (!is_space && !is_sign));

  always_comb begin
    case (wmode_r)
      WMODE_16: begin
        keep_lim = KEEP_16;
        max_pos  = MAX_16;
      end
      WMODE_32: begin
        keep_lim = KEEP_32;
        max_pos  = MAX_32;
      end
      default: begin
        keep_lim = KEEP_64;
        max_pos  = MAX_64;
      end
    endcase
  end

  assign acc_x10 = (acc_r << 3) + (acc_r << 1) + 64'(dig);

  // result from current state
  always_comb begin
    found   = kept_r > {4'd0, sign_r};
    lim     = max_pos + 64'(neg_r);
    ovf     = found && (aovf_r || (acc_r > lim));
    mag     = ovf ? lim : acc_r;
    val     = !found ? 64'd0 : (neg_r ? (64'd0 - mag) : mag);
    sret    = sign_r && !found;
    cnt_sum = 17'(kept_r) + 17'(extra_r);
    cnt     = !found ? 16'd0 : (cnt_sum[16] ? CNT_MAX : cnt_sum[15:0]);
  end

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    sign_nxt  = sign_r;
    acc_nxt   = acc_r;
    kept_nxt  = kept_r;
    extra_nxt = extra_r;
    aovf_nxt  = aovf_r;
    if (in_fire) begin
      if (term) begin
        phase_nxt = PH_SKIP;
        neg_nxt   = 1'b0;
        sign_nxt  = 1'b0;
        acc_nxt   = '0;
        kept_nxt  = '0;
        extra_nxt = '0;
        aovf_nxt  = 1'b0;
      end else if (is_digit) begin
        phase_nxt = PH_NUM;
        if (kept_r < keep_lim) begin
          kept_nxt = kept_r + 5'd1;
          if (!aovf_r) begin
            if (acc_r > ACC_DIV10 || acc_x10 > MAG_TOP) begin
              aovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_x10;
            end
          end
        end else if (extra_r != CNT_MAX) begin
          extra_nxt = extra_r + 16'd1;
        end
      end else if (is_sign) begin
        phase_nxt = PH_NUM;
        sign_nxt  = 1'b1;
        neg_nxt   = (in_tdata == CH_MINUS);
        kept_nxt  = 5'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && term) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmode_r     <= WMODE_32;
      phase_r     <= PH_SKIP;
      neg_r       <= 1'b0;
      sign_r      <= 1'b0;
      acc_r       <= '0;
      kept_r      <= '0;
      extra_r     <= '0;
      aovf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wmode_r <= wmode_t'(cfg_data);
      end
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      sign_r      <= sign_nxt;
      acc_r       <= acc_nxt;
      kept_r      <= kept_nxt;
      extra_r     <= extra_nxt;
      aovf_r      <= aovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && term) begin
      out_data_r <= {cnt, val};
      out_user_r <= {sret, found, ovf};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= KEEP_64)
    else $error("kept character count beyond limit");

  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> kept_r == 5'd0 && acc_r == 64'd0 && extra_r == 16'd0 && !sign_r)
    else $error("parse state not cleared while skipping spaces");

  a_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_user_r[1] |-> out_data_r == '0 && !out_user_r[0])
    else $error("result without digits is not zero");

  a_sign_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[2] |-> !out_user_r[1])
    else $error("sign handed back with a number");

  a_extra_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    extra_r != 16'd0 |-> kept_r == keep_lim)
    else $error("digits discarded before keep limit reached");
`endif

endmodule : decimal_integer_parser
`default_nettype wire
